// ----- rtl/rlrl_pkg.sv -----
// Shared types, codes and saturation helpers for the rate-limited ring logger.
package rlrl_pkg;

	// Action codes carried on the input tuser
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Status codes carried on the output tuser
	localparam logic [2:0] ST_SKIPPED   = 3'd0;
	localparam logic [2:0] ST_APPENDED  = 3'd1;
	localparam logic [2:0] ST_OVERWROTE = 3'd2;
	localparam logic [2:0] ST_READ_OK   = 3'd3;
	localparam logic [2:0] ST_READ_OOR  = 3'd4;
	localparam logic [2:0] ST_CLEARED   = 3'd5;

	// Configuration register indexes
	localparam logic CFG_MIN_SPEED = 1'b0;
	localparam logic CFG_INTERVAL  = 1'b1;

	// Configuration reset values
	localparam logic signed [31:0] MIN_SPEED_RST = 32'sd100;
	localparam logic [31:0]        INTERVAL_RST  = 32'd5000;

	// Saturation bounds
	localparam int S16_MIN = -32768;
	localparam int S16_MAX = 32767;
	localparam int S8_MIN  = -128;
	localparam int S8_MAX  = 127;
	localparam int SOC_MAX = 100;
	localparam int THR_MAX = 1000;

	// Field widths
	localparam int COUNT_W = 17;

	// One logged entry as it sits in the store
	typedef struct packed {
		logic [31:0]        time_ms;
		logic signed [15:0] speed;
		logic signed [15:0] bus_voltage;
		logic signed [15:0] bus_current;
		logic signed [15:0] power;
		logic [6:0]         charge;
		logic signed [7:0]  sink_temp;
		logic signed [7:0]  motor_temp;
		logic [9:0]         throttle;
	} rec_t;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v < S16_MIN) begin
			r = 16'(S16_MIN);
		end else if (v > S16_MAX) begin
			r = 16'(S16_MAX);
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [7:0] sat8(input logic signed [31:0] v);
		logic signed [7:0] r;
		if (v < S8_MIN) begin
			r = 8'(S8_MIN);
		end else if (v > S8_MAX) begin
			r = 8'(S8_MAX);
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic logic [6:0] sat_soc(input logic signed [31:0] v);
		logic [6:0] r;
		if (v < 0) begin
			r = 7'd0;
		end else if (v > SOC_MAX) begin
			r = 7'(SOC_MAX);
		end else begin
			r = v[6:0];
		end
		return r;
	endfunction

	function automatic logic [9:0] sat_thr(input logic signed [31:0] v);
		logic [9:0] r;
		if (v < 0) begin
			r = 10'd0;
		end else if (v > THR_MAX) begin
			r = 10'(THR_MAX);
		end else begin
			r = v[9:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/rlrl_pack.sv -----
// Saturates the raw measurements of a sample beat and packs them into one store entry.
module rlrl_pack (
	input  logic [31:0]        now_ms,
	input  logic signed [31:0] speed_in,
	input  logic signed [31:0] bus_voltage_in,
	input  logic signed [31:0] bus_current_in,
	input  logic signed [31:0] power_in,
	input  logic signed [31:0] charge_in,
	input  logic signed [31:0] sink_temp_in,
	input  logic signed [31:0] motor_temp_in,
	input  logic signed [31:0] throttle_in,
	output rlrl_pkg::rec_t     rec
);

	// Clamp each measurement to its stored range
	always_comb begin
		rec.time_ms     = now_ms;
		rec.speed       = rlrl_pkg::sat16(speed_in);
		rec.bus_voltage = rlrl_pkg::sat16(bus_voltage_in);
		rec.bus_current = rlrl_pkg::sat16(bus_current_in);
		rec.power       = rlrl_pkg::sat16(power_in);
		rec.charge      = rlrl_pkg::sat_soc(charge_in);
		rec.sink_temp   = rlrl_pkg::sat8(sink_temp_in);
		rec.motor_temp  = rlrl_pkg::sat8(motor_temp_in);
		rec.throttle    = rlrl_pkg::sat_thr(throttle_in);
	end

endmodule

// ----- rtl/rate_limited_ring_logger_top.sv -----
// Top level of the rate-limited ring logger: control registers, entry memory, result stage.
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the entry memory takes one write or one read per beat.
// The input stalls only while a result waits on the output and the output is not ready.
// Reset clears the fill count, head slot, last log time and the result valid flag, and loads
// min_speed with 100 and log_interval_ms with 5000. The entry memory is not cleared.
module rate_limited_ring_logger_top #(
	parameter int ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] now_ms, [63:32] speed_in, [95:64] bus_voltage_in, [127:96] bus_current_in,
	// [159:128] power_in, [191:160] charge_in, [223:192] sink_temp_in,
	// [255:224] motor_temp_in, [287:256] throttle_in, [303:288] read_index
	input  logic [303:0] s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [16:0] entry_count, [48:17] time_out, [64:49] speed_out, [80:65] bus_voltage_out,
	// [96:81] bus_current_out, [112:97] power_out, [119:113] charge_out,
	// [127:120] sink_temp_out, [135:128] motor_temp_out, [145:136] throttle_out, [151:146] zero
	output logic [151:0] m_tdata,
	// [2:0] status
	output logic [2:0]   m_tuser,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int PTR_W = $clog2(ENTRIES);
	localparam int REC_W = $bits(rlrl_pkg::rec_t);

	// Configuration registers
	logic signed [31:0] min_speed_q;
	logic [31:0]        interval_q;

	// Control state
	logic [31:0]      last_time_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] head_q;

	// Result stage
	logic                         valid_s1;
	logic [2:0]                   status_s1;
	logic [CNT_W-1:0]             count_s1;
	logic [REC_W-1:0]             rd_q;
	logic [REC_W-1:0]             mem [ENTRIES];

	// Decoded input beat
	logic                  in_acc;
	logic [1:0]            action;
	logic [31:0]           now_ms;
	logic signed [31:0]    speed_in;
	logic [15:0]           read_index;
	rlrl_pkg::rec_t        new_rec;
	rlrl_pkg::rec_t        rd_rec;

	logic                  full;
	logic                  log_ok;
	logic [31:0]           elapsed;
	logic [PTR_W-1:0]      wr_slot;
	logic [PTR_W-1:0]      head_inc;
	logic                  rd_in_range;
	logic [PTR_W-1:0]      idx_p;
	logic [PTR_W:0]        rd_sum;
	logic [PTR_W-1:0]      rd_slot;
	logic [2:0]            status_d;
	logic [CNT_W-1:0]      cnt_d;
	logic [PTR_W-1:0]      head_d;
	logic                  wr_en;
	logic                  rd_en;

	assign action     = s_tuser;
	assign now_ms     = s_tdata[31:0];
	assign speed_in   = $signed(s_tdata[63:32]);
	assign read_index = s_tdata[303:288];

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = !valid_s1 || m_tready;
	assign cfg_ready = 1'b1;

	// Saturate and pack the measurements
	rlrl_pack u_pack (
		.now_ms         (now_ms),
		.speed_in       (speed_in),
		.bus_voltage_in ($signed(s_tdata[95:64])),
		.bus_current_in ($signed(s_tdata[127:96])),
		.power_in       ($signed(s_tdata[159:128])),
		.charge_in      ($signed(s_tdata[191:160])),
		.sink_temp_in   ($signed(s_tdata[223:192])),
		.motor_temp_in  ($signed(s_tdata[255:224])),
		.throttle_in    ($signed(s_tdata[287:256])),
		.rec            (new_rec)
	);

	// Decide the action: logging test, slots and next control state
	always_comb begin
		full     = (cnt_q == CNT_W'(ENTRIES));
		elapsed  = now_ms - last_time_q;
		log_ok   = (speed_in >= min_speed_q) && (elapsed >= interval_q);
		wr_slot  = full ? head_q : cnt_q[PTR_W-1:0];
		head_inc = (head_q == PTR_W'(ENTRIES - 1)) ? '0 : head_q + 1'b1;

		rd_in_range = ({1'b0, read_index} < 17'(cnt_q));
		idx_p       = PTR_W'(read_index);
		rd_sum      = {1'b0, head_q} + {1'b0, idx_p};
		if (rd_sum >= (PTR_W + 1)'(ENTRIES)) begin
			rd_sum = rd_sum - (PTR_W + 1)'(ENTRIES);
		end
		rd_slot = full ? rd_sum[PTR_W-1:0] : idx_p;

		status_d = rlrl_pkg::ST_SKIPPED;
		cnt_d    = cnt_q;
		head_d   = head_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		case (action)
			rlrl_pkg::ACT_SAMPLE: begin
				if (log_ok) begin
					wr_en = in_acc;
					if (full) begin
						status_d = rlrl_pkg::ST_OVERWROTE;
						head_d   = head_inc;
					end else begin
						status_d = rlrl_pkg::ST_APPENDED;
						cnt_d    = cnt_q + 1'b1;
					end
				end
			end
			rlrl_pkg::ACT_READ: begin
				if (rd_in_range) begin
					status_d = rlrl_pkg::ST_READ_OK;
					rd_en    = in_acc;
				end else begin
					status_d = rlrl_pkg::ST_READ_OOR;
				end
			end
			rlrl_pkg::ACT_CLEAR: begin
				status_d = rlrl_pkg::ST_CLEARED;
				cnt_d    = '0;
				head_d   = '0;
			end
			default: begin
				status_d = rlrl_pkg::ST_SKIPPED;
			end
		endcase
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= rlrl_pkg::MIN_SPEED_RST;
			interval_q  <= rlrl_pkg::INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rlrl_pkg::CFG_MIN_SPEED: min_speed_q <= $signed(cfg_data);
				rlrl_pkg::CFG_INTERVAL:  interval_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance control state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
		end else if (in_acc) begin
			cnt_q  <= cnt_d;
			head_q <= head_d;
			if (wr_en) begin
				last_time_q <= now_ms;
			end
		end
	end

	// Entry memory: one write or one registered read per beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= new_rec;
		end
		if (rd_en) begin
			rd_q <= mem[rd_slot];
		end
	end

	// Result stage: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1 <= status_d;
			count_s1  <= cnt_d;
		end
	end

	// Show entry fields only for a successful read
	always_comb begin
		rd_rec = (status_s1 == rlrl_pkg::ST_READ_OK) ? rlrl_pkg::rec_t'(rd_q) : '0;
		m_tvalid = valid_s1;
		m_tuser  = status_s1;
		m_tdata  = '0;
		m_tdata[16:0]    = rlrl_pkg::COUNT_W'(count_s1);
		m_tdata[48:17]   = rd_rec.time_ms;
		m_tdata[64:49]   = rd_rec.speed;
		m_tdata[80:65]   = rd_rec.bus_voltage;
		m_tdata[96:81]   = rd_rec.bus_current;
		m_tdata[112:97]  = rd_rec.power;
		m_tdata[119:113] = rd_rec.charge;
		m_tdata[127:120] = rd_rec.sink_temp;
		m_tdata[135:128] = rd_rec.motor_temp;
		m_tdata[145:136] = rd_rec.throttle;
	end

	// Fill count never exceeds the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("fill count above depth");

	// Head moves away from slot zero only once the store is full
	a_head_full: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != '0) |-> (cnt_q == CNT_W'(ENTRIES)))
		else $error("head advanced before store filled");

	// An overwrite keeps the store full and moves the head
	a_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wr_en && full) |=> (cnt_q == CNT_W'(ENTRIES)) && (head_q == $past(head_inc)))
		else $error("overwrite did not advance head");

	// A logged sample updates the last log time
	a_last_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wr_en) |=> (last_time_q == $past(now_ms)))
		else $error("last log time not updated");

	// A read result reports the count unchanged
	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == rlrl_pkg::ACT_READ) |=> (count_s1 == cnt_q) && $stable(cnt_q))
		else $error("read changed the fill count");

endmodule
